### src/kes_pkg.sv
package kes_pkg;

  // Internal angles keep 28 fraction bits, the same as the field format.
  localparam int FRAC_BITS    = 28;
  localparam int CORDIC_STEPS = 30;
  localparam int ANG_W        = 34;

  localparam logic signed [ANG_W-1:0] PI_Q      = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 34'sd421657428;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] GAIN_Q    = 34'sd163008219;
  localparam logic signed [31:0]      ONE_Q     = 32'sd268435456;
  localparam logic [32:0]             RATIO_LIM = 33'h1_0000_0000;
  localparam logic [5:0]              DIV_TOP   = 6'd33;

  localparam logic [1:0] CFG_ITER_LIMIT = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE  = 2'd1;

  typedef struct packed {
    logic [27:0] eccentricity;
    logic [30:0] mean_anomaly;
  } in_t;

  typedef struct packed {
    logic signed [31:0] eccentric_anomaly;
    logic               status;
    logic [6:0]         passes_used;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CINIT,
    S_ROT,
    S_MUL,
    S_EVAL,
    S_DINIT,
    S_DIV,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic cinit;
    logic rot;
    logic mul;
    logic eval;
    logic dinit;
    logic div;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic               rot_last;
    logic               div_last;
    logic               converged;
    logic signed [31:0] e_out;
  } sts_t;

  // Arctangent of 2^-i in Q6.28, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    begin
      unique case (i)
        5'd0:    v = 34'sd210828714;
        5'd1:    v = 34'sd124459457;
        5'd2:    v = 34'sd65760959;
        5'd3:    v = 34'sd33381290;
        5'd4:    v = 34'sd16755422;
        5'd5:    v = 34'sd8385879;
        5'd6:    v = 34'sd4193963;
        5'd7:    v = 34'sd2097109;
        5'd8:    v = 34'sd1048571;
        5'd9:    v = 34'sd524287;
        5'd10:   v = 34'sd262144;
        5'd11:   v = 34'sd131072;
        5'd12:   v = 34'sd65536;
        5'd13:   v = 34'sd32768;
        5'd14:   v = 34'sd16384;
        5'd15:   v = 34'sd8192;
        5'd16:   v = 34'sd4096;
        5'd17:   v = 34'sd2048;
        5'd18:   v = 34'sd1024;
        5'd19:   v = 34'sd512;
        5'd20:   v = 34'sd256;
        5'd21:   v = 34'sd128;
        5'd22:   v = 34'sd64;
        5'd23:   v = 34'sd32;
        5'd24:   v = 34'sd16;
        5'd25:   v = 34'sd8;
        5'd26:   v = 34'sd4;
        5'd27:   v = 34'sd2;
        5'd28:   v = 34'sd1;
        5'd29:   v = 34'sd1;
        default: v = 34'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

### src/kes_datapath.sv
module kes_datapath
  import kes_pkg::*;
(
  input  logic        clk,
  input  in_t         in_data,
  input  logic [20:0] tol,
  input  cmd_t        cmd,
  output sts_t        sts
);

  logic [27:0]             e_r;
  logic [30:0]             m_r;
  logic signed [32:0]      ang_r;
  logic signed [ANG_W-1:0] x_r, y_r, z_r;
  logic                    flip_r;
  logic [4:0]              rot_cnt_r;
  logic signed [30:0]      es_r, ec_r;
  logic [35:0]             fabs_r;
  logic                    fneg_r;
  logic [29:0]             fp_r;
  logic [29:0]             rem_r;
  logic [33:0]             dsr_r;
  logic [33:0]             q_r;
  logic                    over_r;
  logic [5:0]              div_cnt_r;

  logic signed [ANG_W-1:0] a0, a1, a2;
  logic                    flip;
  logic signed [ANG_W-1:0] dx, dy, atn;
  logic signed [ANG_W-1:0] s_val, c_val;
  logic [ANG_W-1:0]        s_abs, c_abs;
  logic [57:0]             ps, pc;
  logic signed [30:0]      es_val, ec_val;
  logic signed [35:0]      f_val;
  logic [35:0]             f_abs;
  logic signed [31:0]      fp_val;
  logic [30:0]             rem_sh;
  logic                    qbit;
  logic [30:0]             rem_sub;
  logic [32:0]             mag;
  logic signed [35:0]      ratio, e_new;
  logic signed [32:0]      e_clamped;

  // One wrap into [-pi, pi], then fold into the right half plane.
  always_comb begin
    a0 = ANG_W'(ang_r);
    if (a0 > PI_Q) begin
      a1 = a0 - TWO_PI_Q;
    end else if (a0 < -PI_Q) begin
      a1 = a0 + TWO_PI_Q;
    end else begin
      a1 = a0;
    end
    flip = 1'b0;
    a2   = a1;
    if (a1 > HALF_PI_Q) begin
      a2   = a1 - PI_Q;
      flip = 1'b1;
    end else if (a1 < -HALF_PI_Q) begin
      a2   = a1 + PI_Q;
      flip = 1'b1;
    end
  end

  assign dx  = y_r >>> rot_cnt_r;
  assign dy  = x_r >>> rot_cnt_r;
  assign atn = atan_lut(rot_cnt_r);

  // Products truncate toward zero, so the magnitudes are multiplied.
  always_comb begin
    s_val  = flip_r ? -y_r : y_r;
    c_val  = flip_r ? -x_r : x_r;
    s_abs  = s_val[ANG_W-1] ? ANG_W'(-s_val) : ANG_W'(s_val);
    c_abs  = c_val[ANG_W-1] ? ANG_W'(-c_val) : ANG_W'(c_val);
    ps     = e_r * s_abs[29:0];
    pc     = e_r * c_abs[29:0];
    es_val = s_val[ANG_W-1] ? -signed'({1'b0, ps[57:28]}) : signed'({1'b0, ps[57:28]});
    ec_val = c_val[ANG_W-1] ? -signed'({1'b0, pc[57:28]}) : signed'({1'b0, pc[57:28]});
  end

  always_comb begin
    f_val  = 36'(ang_r) - 36'(es_r) - signed'({5'b0, m_r});
    f_abs  = f_val[35] ? 36'(-f_val) : 36'(f_val);
    fp_val = ONE_Q - 32'(ec_r);
    if (fp_val < 32'sd1) begin
      fp_val = 32'sd1;
    end
  end

  always_comb begin
    rem_sh  = {rem_r, dsr_r[33]};
    qbit    = rem_sh >= {1'b0, fp_r};
    rem_sub = qbit ? rem_sh - {1'b0, fp_r} : rem_sh;
  end

  always_comb begin
    if (over_r || (q_r > {1'b0, RATIO_LIM})) begin
      mag = RATIO_LIM;
    end else begin
      mag = q_r[32:0];
    end
    ratio = fneg_r ? -signed'({3'b0, mag}) : signed'({3'b0, mag});
    e_new = 36'(ang_r) - ratio;
    if (e_new > 36'sd2147483647) begin
      e_clamped = 33'sd2147483647;
    end else if (e_new < -36'sd2147483648) begin
      e_clamped = -33'sd2147483648;
    end else begin
      e_clamped = 33'(e_new);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r   <= in_data.eccentricity;
      m_r   <= in_data.mean_anomaly;
    end
    if (cmd.load) begin
      ang_r <= 33'(signed'({2'b00, in_data.mean_anomaly}) +
                   ((in_data.mean_anomaly < 31'(PI_Q)) ?
                    signed'({6'b0, in_data.eccentricity[27:1]}) :
                    -signed'({6'b0, in_data.eccentricity[27:1]})));
    end else if (cmd.update && !sts.converged) begin
      ang_r <= e_clamped;
    end
    if (cmd.cinit) begin
      x_r       <= GAIN_Q;
      y_r       <= '0;
      z_r       <= a2;
      flip_r    <= flip;
      rot_cnt_r <= '0;
    end else if (cmd.rot) begin
      if (!z_r[ANG_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atn;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atn;
      end
      rot_cnt_r <= rot_cnt_r + 5'd1;
    end
    if (cmd.mul) begin
      es_r <= es_val;
      ec_r <= ec_val;
    end
    if (cmd.eval) begin
      fabs_r <= f_abs;
      fneg_r <= f_val[35];
      fp_r   <= fp_val[29:0];
    end
    if (cmd.dinit) begin
      over_r    <= fabs_r >= {fp_r, 6'b0};
      rem_r     <= fabs_r[35:6];
      dsr_r     <= {fabs_r[5:0], 28'b0};
      q_r       <= '0;
      div_cnt_r <= DIV_TOP;
    end else if (cmd.div) begin
      rem_r     <= rem_sub[29:0];
      dsr_r     <= {dsr_r[32:0], 1'b0};
      q_r       <= {q_r[32:0], qbit};
      div_cnt_r <= div_cnt_r - 6'd1;
    end
  end

  always_comb begin
    sts.rot_last  = rot_cnt_r == 5'(CORDIC_STEPS - 1);
    sts.div_last  = div_cnt_r == 6'd0;
    sts.converged = mag < {12'b0, tol};
    if (ang_r > 33'sd2147483647) begin
      sts.e_out = 32'sd2147483647;
    end else if (ang_r < -33'sd2147483648) begin
      sts.e_out = -32'sd2147483648;
    end else begin
      sts.e_out = 32'(ang_r);
    end
  end

endmodule

### src/kes_ctrl.sv
module kes_ctrl
  import kes_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic [6:0] iter_limit,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [6:0] passes_r, passes_nxt;
  logic       stat_r, stat_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    passes_r   <= passes_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    passes_nxt    = passes_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          passes_nxt = '0;
          if (iter_limit == 7'd0) begin
            stat_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CINIT;
          end
        end
      end
      S_CINIT: begin
        cmd.cinit = 1'b1;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rot = 1'b1;
        if (sts.rot_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        passes_nxt = passes_r + 7'd1;
        if (sts.converged) begin
          stat_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (passes_r + 7'd1 == iter_limit) begin
          stat_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CINIT;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.eccentric_anomaly = sts.e_out;
          out_data_nxt.status            = stat_r;
          out_data_nxt.passes_used       = passes_r;
          state_nxt                      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/kepler_eccentric_anomaly_solver_top.sv
// Each input transfer runs P Newton passes before its result is loaded, where P is the number
// of Newton passes (P = 0 when the iteration limit is zero).
// Throughput: one item at a time; the next input transfer can be taken in the cycle after
// the result is loaded into the output register, even while that result waits.
// Reset: synchronous, active low; clears the controller and restores limit 20, tolerance 16.
module kepler_eccentric_anomaly_solver_top
  import kes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  // Each Newton pass walks through a schedule in the controller: it wraps
  // and folds the angle, runs the CORDIC rotations for sine and cosine,
  // forms the two eccentricity products, then the residual and derivative,
  // and runs a restoring divider that sets up and then produces a
  // thirty-four-bit quotient one bit at a time.  A final step checks the
  // correction against the tolerance and updates E unless it is below it.

  logic [6:0]  iter_limit_r;
  logic [20:0] tol_r;
  cmd_t        cmd;
  sts_t        sts;

  // Configuration registers. Writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r <= 7'd20;
      tol_r        <= 21'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ITER_LIMIT: iter_limit_r <= cfg_data[6:0];
        CFG_TOLERANCE:  tol_r        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The controller sequences the passes and owns the output register.
  kes_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .iter_limit (iter_limit_r),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds E, the CORDIC rotator, the multipliers and the divider.
  kes_datapath u_dp (
    .clk     (clk),
    .in_data (in_data),
    .tol     (tol_r),
    .cmd     (cmd),
    .sts     (sts)
  );

`ifndef SYNTHESIS
  // Once an item is taken the block stays busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous item still in work");

  // A converged result always took at least one pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.status) |-> (out_data.passes_used != 7'd0))
    else $error("converged result with zero passes");

  // Giving up means exactly the configured number of passes ran.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.passes_used == iter_limit_r))
    else $error("limit status with wrong pass count");
`endif

endmodule

### tb/kepler_eccentric_anomaly_solver_top_tb.sv
module kepler_eccentric_anomaly_solver_top_tb;
  import kes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog allows several times the slowest item, 127 Newton passes,
  // plus the longest receiver stall.
  localparam int STALL_LIMIT = 60000;
  localparam longint INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ITER_LIMIT;
  logic [20:0] cfg_data = '0;

  kepler_eccentric_anomaly_solver_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Local copy of the configuration registers, updated whenever they are written.
  logic [6:0]  model_limit = 7'd20;
  logic [20:0] model_tol   = 21'd16;

  // Constant tables for the predictor, derived here from integer series.
  longint atan_tab [0:CORDIC_STEPS-1];
  longint pi_val, half_pi_val, two_pi_val, gain_val;

  out_t pending_anomalies [$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;

  function automatic longint unsigned atan_inv_series(input longint unsigned n);
    longint unsigned p, sum, t, k;
    p = (64'd1 << 62) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) sum -= t;
      else sum += t;
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic longint round_from62(input longint unsigned v, input int s);
    return longint'((v + (64'd1 << (s - 1))) >> s);
  endfunction

  task automatic build_tables();
    longint unsigned quarter, v, t, g2, r, c, sq, bit_mask;
    logic [127:0] prod;
    quarter = 4 * atan_inv_series(64'd5) - atan_inv_series(64'd239);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        v = quarter;
      end else begin
        v = 0;
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          t = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
          if (k % 2 == 1) v -= t;
          else v += t;
        end
      end
      atan_tab[i] = round_from62(v, 62 - FRAC_BITS);
    end
    pi_val      = round_from62(quarter, 60 - FRAC_BITS);
    half_pi_val = round_from62(quarter, 61 - FRAC_BITS);
    two_pi_val  = round_from62(quarter, 59 - FRAC_BITS);
    // The gain correction is found as 1/sqrt of the product of (1 + 4^-i),
    // one result bit at a time.
    g2 = 64'd1 << 62;
    for (int i = 0; i < CORDIC_STEPS; i++) g2 += g2 >> (2 * i);
    r = 0;
    for (bit_mask = 64'd1 << 61; bit_mask != 0; bit_mask >>= 1) begin
      c = r | bit_mask;
      prod = {64'd0, c} * {64'd0, c};
      sq = prod[125:62];
      prod = {64'd0, sq} * {64'd0, g2};
      t = prod[125:62];
      if (t <= (64'd1 << 62)) r = c;
    end
    gain_val = round_from62(r, 62 - FRAC_BITS);
  endtask

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Fixed-point product, truncated toward zero and saturated.
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] prod;
    longint unsigned m;
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    if ((prod >> (FRAC_BITS + 64)) != 0) m = INT64_MAX;
    else m = prod[FRAC_BITS +: 64];
    if (m > INT64_MAX) m = INT64_MAX;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Fixed-point quotient for a positive divisor, truncated and clamped to +-lim.
  function automatic longint fx_div(input longint num, input longint den,
                                    input longint unsigned lim);
    logic [127:0] q;
    q = ({64'd0, magnitude(num)} << FRAC_BITS) / {64'd0, den};
    if (q > {64'd0, lim}) q = {64'd0, lim};
    return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic cordic_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    logic flip;
    x = gain_val;
    y = 0;
    flip = 1'b0;
    while (ang > pi_val) ang -= two_pi_val;
    while (ang < -pi_val) ang += two_pi_val;
    if (ang > half_pi_val) begin
      ang -= pi_val;
      flip = 1'b1;
    end else if (ang < -half_pi_val) begin
      ang += pi_val;
      flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  // Newton iteration on E - e*sin(E) = M at the current register settings.
  task automatic solve_kepler(input in_t item, output out_t res);
    longint one_v, ecc, ma, tol, ang, s, c, f, fp, ratio, mag;
    int iter, passes;
    one_v = 64'sd1 << FRAC_BITS;
    ecc = longint'(item.eccentricity);
    ma = longint'(item.mean_anomaly);
    tol = longint'(model_tol);
    passes = 0;
    ang = (ma < pi_val) ? ma + (ecc >>> 1) : ma - (ecc >>> 1);
    for (iter = 0; iter < model_limit; iter++) begin
      cordic_sincos(ang, s, c);
      f = ang - fx_mul(ecc, s) - ma;
      fp = one_v - fx_mul(ecc, c);
      if (fp < 1) fp = 1;
      ratio = fx_div(f, fp, 64'd1 << (FRAC_BITS + 4));
      passes = iter + 1;
      mag = (ratio < 0) ? -ratio : ratio;
      if (mag < tol) break;
      ang -= ratio;
      if (ang > (64'sd1 << (FRAC_BITS + 3)) - 1) ang = (64'sd1 << (FRAC_BITS + 3)) - 1;
      if (ang < -(64'sd1 << (FRAC_BITS + 3))) ang = -(64'sd1 << (FRAC_BITS + 3));
    end
    if (ang > 64'sd2147483647) ang = 64'sd2147483647;
    if (ang < -64'sd2147483648) ang = -64'sd2147483648;
    res.eccentric_anomaly = ang[31:0];
    res.status = (iter == model_limit);
    res.passes_used = passes[6:0];
  endtask

  // Sends one item. The sender works in bursts; between bursts valid may drop for a
  // random gap. Within a burst valid stays high and only the payload changes,
  // so valid never gets two nonblocking assignments in one time step.
  task automatic send_item(input in_t item);
    int gap;
    out_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    // The transfer happened at this edge; the prediction uses the registers
    // that were in force for it.
    solve_kepler(item, res);
    pending_anomalies.push_back(res);
  endtask

  // Lowers valid and waits until every predicted result has been taken, then
  // lets the block settle before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_anomalies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Writes both registers; only called while the block is idle.
  task automatic set_config(input int limit, input int tol);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ITER_LIMIT;
    cfg_data <= 21'(limit & 'h7F);
    @(posedge clk);
    model_limit = 7'(limit);
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= 21'(tol);
    @(posedge clk);
    model_tol = 21'(tol);
    cfg_we <= 1'b0;
  endtask

  function automatic in_t make_item(input int unsigned ecc, input int unsigned ma);
    in_t it;
    it.eccentricity = ecc[27:0];
    it.mean_anomaly = ma[30:0];
    return it;
  endfunction

  // Random item: eccentricity spread over low, high, extreme and uniform values, mean
  // anomaly mostly inside one revolution with some near pi and some beyond 2*pi.
  function automatic in_t random_item();
    int unsigned ecc, ma;
    case ($urandom_range(0, 9))
      0:       ecc = $urandom_range(0, 'hFFFF);
      1, 2:    ecc = $urandom_range('hE00_0000, 'hFFF_FFFF);
      3:       ecc = ($urandom_range(0, 1) == 1) ? 'hFFF_FFFF : 0;
      default: ecc = $urandom_range(0, 'hFFF_FFFF);
    endcase
    case ($urandom_range(0, 19))
      0:       ma = $urandom_range(0, 'h7FFF_FFFF);
      1:       ma = int'(pi_val) - 8 + $urandom_range(0, 16);
      2:       ma = $urandom_range(0, 64);
      default: ma = $urandom_range(0, int'(two_pi_val));
    endcase
    return make_item(ecc, ma);
  endfunction

  // Items at reset settings: field extremes and the start-value switch at pi.
  task automatic test_directed_basics();
    send_item(make_item(0, 0));
    send_item(make_item('hFFF_FFFF, 0));
    send_item(make_item(0, int'(two_pi_val)));
    send_item(make_item('hFFF_FFFF, int'(two_pi_val)));
    send_item(make_item('h800_0000, int'(pi_val) - 1));
    send_item(make_item('h800_0000, int'(pi_val)));
    send_item(make_item('h800_0000, int'(pi_val) + 1));
    send_item(make_item('hFFF_FFFF, int'(pi_val)));
    send_item(make_item('hFFF_FFFF, 1));
    send_item(make_item('h555_5555, 'h2AAA_AAAA));
    send_item(make_item('hAAA_AAAA, 'h5555_5555));
    drain();
  endtask

  // Angles beyond 2*pi up to the full field width force the wrap in sin/cos.
  task automatic test_angle_wrap();
    send_item(make_item(0, 'h7FFF_FFFF));
    send_item(make_item('hFFF_FFFF, 'h7FFF_FFFF));
    send_item(make_item('h400_0000, int'(two_pi_val) + 1));
    drain();
  endtask

  // A limit of zero runs no pass and returns the start value with status one.
  task automatic test_limit_zero();
    set_config(0, 16);
    send_item(make_item('h800_0000, 'h1000_0000));
    send_item(make_item('hFFF_FFFF, int'(pi_val)));
    send_item(make_item(0, 0));
    drain();
  endtask

  // Tolerance extremes, including zero, which can never stop the loop, and a
  // single-pass limit.
  task automatic test_tolerance_extremes();
    set_config(20, 0);
    send_item(make_item('h800_0000, 'h2000_0000));
    drain();
    set_config(1, 'h1F_FFFF);
    send_item(make_item('hFFF_FFFF, 'h3000_0000));
    send_item(make_item(0, 'h1000_0000));
    drain();
    set_config(1, 1);
    send_item(make_item('hFFF_FFFF, 'h0800_0000));
    drain();
  endtask

  // Random items across several register settings. The largest limit runs
  // only a handful of items because each one can run up to 127 Newton passes.
  task automatic test_random_settings();
    int limits [7] = '{20, 1, 64, 5, 127, 2, 33};
    int tols   [7] = '{16, 1, 1, 'h1F_FFFF, 1, 'h10_0000, 300};
    int counts [7] = '{300, 200, 150, 200, 12, 150, 80};
    for (int p = 0; p < 7; p++) begin
      set_config(limits[p], tols[p]);
      for (int n = 0; n < counts[p]; n++) send_item(random_item());
      drain();
    end
  endtask

  // The receiver stalls on a pattern of its own: always ready, ready one
  // cycle in N, or random, picking a new mode at random intervals.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;
  int stall_period = 1;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_period = $urandom_range(2, 12);
      mode_left = $urandom_range(50, 400);
    end
    mode_left--;
    stall_phase = (stall_phase + 1) % stall_period;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= (stall_phase == 0);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Result checker and watchdog. Each result transfer is compared with the
  // oldest prediction; the watchdog counts cycles without any transfer.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (pending_anomalies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: E=%0d status=%0d passes=%0d",
                     out_data.eccentric_anomaly, out_data.status, out_data.passes_used);
        end else begin
          want = pending_anomalies.pop_front();
          if (out_data.eccentric_anomaly !== want.eccentric_anomaly ||
              out_data.status !== want.status ||
              out_data.passes_used !== want.passes_used) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected E=%0d status=%0d passes=%0d, got E=%0d status=%0d passes=%0d",
                       want.eccentric_anomaly, want.status, want.passes_used,
                       out_data.eccentric_anomaly, out_data.status, out_data.passes_used);
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    build_tables();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_basics();
    test_angle_wrap();
    test_limit_zero();
    test_tolerance_extremes();
    test_random_settings();
    drain();
    if (mismatches == 0 && pending_anomalies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
